// ===== rtl/itda_pkg.sv =====
package itda_pkg;

  localparam int unsigned DIGIT_W = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // double dabble: a digit of five or more gets three added before the shift
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic neg;
  } emit_cmd_t;

endpackage

// ===== rtl/integer_to_decimal_ascii_top.sv =====
// signed binary to decimal ascii, one character word per strobe, msd first
// the bit-serial dabble converts the magnitude first, then the emitter sends a minus sign
// for a negative value, followed by the digits with leading zeros skipped
// a new value is accepted only once the last character of the previous one has gone out
// the receiver cannot stall: each character word is strobed for one cycle
// reset is asynchronous, active low, and returns the block to idle
module integer_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  strobe_o,
  output logic [7:0]            character_o,
  output logic                  last_o
);
  import itda_pkg::*;

  // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
  localparam int unsigned NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

  ctrl_state_e           state_q, state_d;
  logic                  neg_q, neg_d;
  logic                  accept;
  logic                  conv_done;
  logic                  emit_active;
  logic [VALUE_BITS-1:0] mag;
  logic [NDIG*4-1:0]     bcd;
  emit_cmd_t             emit_cmd;

  assign accept = start && !busy;
  // unsigned magnitude, so the most negative value converts correctly
  assign mag    = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;

  always_comb begin
    state_d       = state_q;
    neg_d         = neg_q;
    busy          = 1'b1;
    emit_cmd.load = 1'b0;
    emit_cmd.neg  = neg_q;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          neg_d   = value_i[VALUE_BITS-1];
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          emit_cmd.load = 1'b1;
          state_d       = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_active) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  itda_dabble #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_dabble (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(accept),
    .mag_i (mag),
    .done_o(conv_done),
    .bcd_o (bcd)
  );

  itda_emit #(
    .NDIG(NDIG)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (emit_cmd),
    .bcd_i      (bcd),
    .active_o   (emit_active),
    .strobe_o   (strobe_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

// ===== rtl/itda_dabble.sv =====
module itda_dabble #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NDIG       = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  logic [VALUE_BITS-1:0] mag_i,
  output logic                  done_o,
  output logic [NDIG*4-1:0]     bcd_o
);
  import itda_pkg::*;

  localparam int unsigned CW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned BCDW = NDIG * DIGIT_W;

  logic                  active_q, active_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCDW-1:0]       bcd_q, bcd_d;
  logic [BCDW-1:0]       adj;

  // add-3 correction on every digit, all digits in parallel
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DABBLE_ADJ;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    if (load_i) begin
      active_d = 1'b1;
      cnt_d    = CW'(VALUE_BITS);
      bin_d    = mag_i;
      bcd_d    = '0;
    end else if (active_q) begin
      bcd_d = {adj[BCDW-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ===== rtl/itda_emit.sv =====
module itda_emit #(
  parameter int unsigned NDIG = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itda_pkg::emit_cmd_t  cmd_i,
  input  logic [NDIG*4-1:0]    bcd_i,
  output logic                 active_o,
  output logic                 strobe_o,
  output logic [7:0]           character_o,
  output logic                 last_o
);
  import itda_pkg::*;

  localparam int unsigned BCDW = NDIG * DIGIT_W;
  localparam int unsigned DCW  = $clog2(NDIG + 1);

  logic               active_q, active_d;
  logic               sign_q, sign_d;
  logic               started_q, started_d;
  logic [DCW-1:0]     dcnt_q, dcnt_d;
  logic [BCDW-1:0]    digs_q, digs_d;
  logic               strobe_q, strobe_d;
  logic [7:0]         char_q, char_d;
  logic               last_q, last_d;
  logic [DIGIT_W-1:0] top_dig;
  logic               final_dig;
  logic               show;

  assign top_dig   = digs_q[BCDW-1 -: DIGIT_W];
  assign final_dig = (dcnt_q == DCW'(1));
  // leading zeros are dropped, but the final digit always shows
  assign show      = started_q || (top_dig != '0) || final_dig;

  always_comb begin
    active_d  = active_q;
    sign_d    = sign_q;
    started_d = started_q;
    dcnt_d    = dcnt_q;
    digs_d    = digs_q;
    strobe_d  = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    if (cmd_i.load) begin
      active_d  = 1'b1;
      sign_d    = cmd_i.neg;
      started_d = 1'b0;
      dcnt_d    = DCW'(NDIG);
      digs_d    = bcd_i;
    end else if (active_q) begin
      if (sign_q) begin
        sign_d   = 1'b0;
        strobe_d = 1'b1;
        char_d   = CHAR_MINUS;
        last_d   = 1'b0;
      end else begin
        strobe_d  = show;
        char_d    = CHAR_ZERO + {4'd0, top_dig};
        last_d    = final_dig;
        started_d = started_q | show;
        digs_d    = {digs_q[BCDW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        dcnt_d    = dcnt_q - 1'b1;
        if (final_dig) begin
          active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      sign_q    <= 1'b0;
      started_q <= 1'b0;
      dcnt_q    <= '0;
      strobe_q  <= 1'b0;
    end else begin
      active_q  <= active_d;
      sign_q    <= sign_d;
      started_q <= started_d;
      dcnt_q    <= dcnt_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digs_q <= digs_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign active_o    = active_q;
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule
